### rtl/core/hampel_outlier_filter_core_macros.svh
// assertion macros for the hampel outlier filter core
// no dependencies; included by the modules that carry assertions
`ifndef HAMPEL_OUTLIER_FILTER_CORE_MACROS_SVH
`define HAMPEL_OUTLIER_FILTER_CORE_MACROS_SVH
`ifndef SYNTH
`define HOF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("hof check failed");
`define HOF_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("hof check failed");
`else
`define HOF_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define HOF_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### rtl/core/hof_pkg.sv
// shared types and constants for the hampel outlier filter core
// no dependencies
package hof_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int LIMIT_BITS  = 12;
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 12'd1139;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          frame_end;
    } t_in_beat;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] cleaned;
        logic                          replaced;
        logic                          frame_done;
    } t_out_beat;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_LOAD,
        S_LOAD_WAIT,
        S_SORT_VAL,
        S_MEDIAN,
        S_DEV,
        S_SORT_DEV,
        S_MAD,
        S_JUDGE,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic accept;
        logic rd;
        logic clear;
        logic centre;
        logic sort;
        logic sort_odd;
        logic take_med;
        logic take_dev;
        logic take_mad;
        logic judge;
        logic emit;
        logic frame_done;
        logic pos_clear;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

### rtl/core/hampel_outlier_filter_core.sv
// hampel outlier filter core: top level joining controller and datapath
// depends on hof_pkg, hof_ctrl and hof_datapath
//
// usage
// - input channel: i_in_valid / o_in_stall / i_in_data (sample, frame_end);
//   a beat moves when valid is high and stall is low
// - output channel: o_out_valid / i_out_stall / o_out_data (cleaned,
//   replaced, frame_done), held in an output register
// - config: i_cfg_we writes i_cfg_data into the 12-bit outlier limit
//   (unsigned q4.8, reset 1139); write only while the core is idle
// - each sample is stored, then a centre HALF_WINDOW samples back is judged;
//   a frame_end beat flushes every pending centre, oldest first, and the
//   last result carries frame_done
// - per result, the time is set by the window load (len = window size)
//   through the single store read port and by two odd-even transposition
//   sorts; a beat's first result also passes through the start state
// - one item is worked on at a time; o_in_stall is low only when idle
// - a stalled receiver holds the result register; the core waits before
//   emitting the next result, but the next input beat is taken as soon as
//   the last result of the current one is in the register
// - synchronous active-low reset clears pointers, frame count, state and
//   output valid and holds o_in_stall high; the window store needs no clearing
module hampel_outlier_filter_core #(
    parameter int HALF_WINDOW = 15
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  hof_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output hof_pkg::t_out_beat o_out_data,
    input  logic               i_cfg_we,
    input  logic [hof_pkg::LIMIT_BITS-1:0] i_cfg_data
);
    import hof_pkg::*;

    localparam int WIN = 2 * HALF_WINDOW + 1;
    localparam int AW  = $clog2(WIN);
    localparam int PW  = $clog2(WIN + 1);

    t_cmd cmd;
    t_sts sts;
    logic [AW-1:0] rd_age;
    logic [AW-1:0] sel;
    logic [PW-1:0] pos;

    // sequencing of load, sort, judge and emit
    hof_ctrl #(
        .HALF_WINDOW(HALF_WINDOW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_frame_end (i_in_data.frame_end),
        .i_sts       (sts),
        .i_pos       (pos),
        .o_cmd       (cmd),
        .o_rd_age    (rd_age),
        .o_sel       (sel)
    );

    // store, lanes, arithmetic and result register
    hof_datapath #(
        .HALF_WINDOW(HALF_WINDOW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_rd_age    (rd_age),
        .i_sel       (sel),
        .o_pos       (pos),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

### rtl/core/hof_datapath.sv
// datapath: window store, sort lanes, median/mad arithmetic, output register
// depends on hof_pkg
module hof_datapath #(
    parameter int HALF_WINDOW = 15,
    localparam int WIN = 2 * HALF_WINDOW + 1,
    localparam int AW  = $clog2(WIN),
    localparam int PW  = $clog2(WIN + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hof_pkg::t_cmd     i_cmd,
    output hof_pkg::t_sts     o_sts,
    input  logic [AW-1:0]     i_rd_age,
    input  logic [AW-1:0]     i_sel,
    output logic [PW-1:0]     o_pos,
    input  hof_pkg::t_in_beat i_in_data,
    input  logic              i_cfg_we,
    input  logic [hof_pkg::LIMIT_BITS-1:0] i_cfg_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output hof_pkg::t_out_beat o_out_data
);
    import hof_pkg::*;

    localparam int LW = SAMPLE_BITS + 1;
    localparam int PRW = LIMIT_BITS + SAMPLE_BITS;

    logic [SAMPLE_BITS-1:0] mem [WIN];
    logic [SAMPLE_BITS-1:0] r_rdata;
    logic r_rd_vld, r_rd_centre;
    logic [AW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_pos, n_pos;
    logic [AW:0] base;
    logic [AW-1:0] rd_addr;
    logic [LIMIT_BITS-1:0] r_limit;

    logic signed [LW-1:0] r_lane [WIN];
    logic signed [LW-1:0] n_lane [WIN];
    logic [WIN-1:0] r_lvld, n_lvld;
    logic [WIN-1:0] swp;

    logic signed [LW-1:0] r_med;
    logic [SAMPLE_BITS-1:0] r_mad;
    logic signed [SAMPLE_BITS-1:0] r_centre;
    logic [PRW-1:0] r_prod;
    logic [SAMPLE_BITS-1:0] r_dist;
    logic signed [LW-1:0] cdiff;
    logic rep;
    logic r_out_valid;
    t_out_beat r_out;

    // pointers
    always_comb begin
        n_wp  = r_wp;
        n_pos = r_pos;
        if (i_cmd.accept) begin
            n_wp = (r_wp == AW'(WIN - 1)) ? '0 : r_wp + 1'b1;
            if (r_pos != PW'(WIN)) begin
                n_pos = r_pos + 1'b1;
            end
        end
        if (i_cmd.pos_clear) begin
            n_pos = '0;
        end
    end

    // slot of the sample with the given age
    always_comb begin
        base = {1'b0, r_wp} + (AW + 1)'(WIN - 1) - {1'b0, i_rd_age};
        if (base >= (AW + 1)'(WIN)) begin
            rd_addr = AW'(base - (AW + 1)'(WIN));
        end else begin
            rd_addr = base[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            mem[r_wp] <= i_in_data.sample;
        end
        if (i_cmd.rd) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_pos       <= '0;
            r_rd_vld    <= 1'b0;
            r_rd_centre <= 1'b0;
            r_limit     <= LIMIT_RESET;
        end else begin
            r_wp        <= n_wp;
            r_pos       <= n_pos;
            r_rd_vld    <= i_cmd.rd;
            r_rd_centre <= i_cmd.centre;
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    // odd-even transposition step, invalid lanes sort above all
    always_comb begin
        swp = '0;
        for (int j = 0; j < WIN - 1; j++) begin
            if ((j % 2) == int'(i_cmd.sort_odd)) begin
                swp[j] = (!r_lvld[j] && r_lvld[j+1]) ||
                         (r_lvld[j] && r_lvld[j+1] && (r_lane[j] > r_lane[j+1]));
            end
        end
        for (int j = 0; j < WIN; j++) begin
            n_lane[j] = r_lane[j];
            n_lvld[j] = r_lvld[j];
            if (r_rd_vld) begin
                if (j == 0) begin
                    n_lane[j] = LW'(signed'(r_rdata));
                    n_lvld[j] = 1'b1;
                end else begin
                    n_lane[j] = r_lane[j-1];
                    n_lvld[j] = r_lvld[j-1];
                end
            end else if (i_cmd.sort) begin
                if (j < WIN - 1) begin
                    if (swp[j]) begin
                        n_lane[j] = r_lane[j+1];
                        n_lvld[j] = r_lvld[j+1];
                    end
                end
                if (j > 0) begin
                    if (swp[j-1]) begin
                        n_lane[j] = r_lane[j-1];
                        n_lvld[j] = r_lvld[j-1];
                    end
                end
            end else if (i_cmd.take_dev) begin
                n_lane[j] = (r_lane[j] < r_med) ? r_med - r_lane[j] : r_lane[j] - r_med;
            end
            if (i_cmd.clear) begin
                n_lvld[j] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < WIN; j++) begin
            r_lane[j] <= n_lane[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvld <= '0;
        end else begin
            r_lvld <= n_lvld;
        end
    end

    assign cdiff = LW'(r_centre) - r_med;

    always_ff @(posedge i_clk) begin
        if (r_rd_vld && r_rd_centre) begin
            r_centre <= r_rdata;
        end
        if (i_cmd.take_med) begin
            r_med <= r_lane[i_sel];
        end
        if (i_cmd.take_mad) begin
            r_mad <= r_lane[i_sel][SAMPLE_BITS-1:0];
        end
        if (i_cmd.judge) begin
            r_prod <= PRW'(r_limit) * PRW'(r_mad);
            r_dist <= (cdiff < 0) ? SAMPLE_BITS'(-cdiff) : SAMPLE_BITS'(cdiff);
        end
    end

    assign rep = (r_mad != '0) && ({4'b0, r_dist, 8'b0} > r_prod);

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.cleaned    <= rep ? r_med[SAMPLE_BITS-1:0] : r_centre;
            r_out.replaced   <= rep;
            r_out.frame_done <= i_cmd.frame_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.out_free = !r_out_valid || !i_out_stall;
    assign o_pos          = r_pos;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out;

endmodule

### rtl/core/hof_ctrl.sv
// controller: sequences load, two sorts, judge and emit for each centre
// depends on hof_pkg and the core macros header
`include "hampel_outlier_filter_core_macros.svh"
module hof_ctrl #(
    parameter int HALF_WINDOW = 15,
    localparam int WIN = 2 * HALF_WINDOW + 1,
    localparam int AW  = $clog2(WIN),
    localparam int PW  = $clog2(WIN + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic          i_frame_end,
    input  hof_pkg::t_sts i_sts,
    input  logic [PW-1:0] i_pos,
    output hof_pkg::t_cmd o_cmd,
    output logic [AW-1:0] o_rd_age,
    output logic [AW-1:0] o_sel
);
    import hof_pkg::*;

    t_state r_state, n_state;
    logic r_last, n_last;
    logic [AW-1:0] r_age, n_age;
    logic [AW-1:0] r_idx, n_idx;
    logic [AW-1:0] r_round, n_round;
    logic [PW-1:0] span, len, pm1;

    assign span = PW'(r_age) + PW'(HALF_WINDOW + 1);
    assign len  = (i_pos < span) ? i_pos : span;
    assign pm1  = i_pos - 1'b1;
    assign o_sel = AW'(len >> 1);
    assign o_rd_age = r_idx;
    assign o_in_stall = (r_state != S_IDLE) || !i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_last  <= 1'b0;
            r_age   <= '0;
            r_idx   <= '0;
            r_round <= '0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
            r_age   <= n_age;
            r_idx   <= n_idx;
            r_round <= n_round;
        end
    end

    always_comb begin
        n_state = r_state;
        n_last  = r_last;
        n_age   = r_age;
        n_idx   = r_idx;
        n_round = r_round;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_rst_n) begin
                    o_cmd.accept = 1'b1;
                    n_last  = i_frame_end;
                    n_state = S_START;
                end
            end
            S_START: begin
                n_idx = '0;
                if (r_last) begin
                    n_age   = (pm1 > PW'(HALF_WINDOW)) ? AW'(HALF_WINDOW) : AW'(pm1);
                    n_state = S_LOAD;
                end else if (i_pos > PW'(HALF_WINDOW)) begin
                    n_age   = AW'(HALF_WINDOW);
                    n_state = S_LOAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_LOAD: begin
                o_cmd.rd     = 1'b1;
                o_cmd.clear  = (r_idx == '0);
                o_cmd.centre = (r_idx == r_age);
                if (PW'(r_idx) == len - 1'b1) begin
                    n_state = S_LOAD_WAIT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_LOAD_WAIT: begin
                n_round = '0;
                n_state = S_SORT_VAL;
            end
            S_SORT_VAL, S_SORT_DEV: begin
                o_cmd.sort     = 1'b1;
                o_cmd.sort_odd = r_round[0];
                if (r_round == AW'(WIN - 1)) begin
                    n_round = '0;
                    n_state = (r_state == S_SORT_VAL) ? S_MEDIAN : S_MAD;
                end else begin
                    n_round = r_round + 1'b1;
                end
            end
            S_MEDIAN: begin
                o_cmd.take_med = 1'b1;
                n_state = S_DEV;
            end
            S_DEV: begin
                o_cmd.take_dev = 1'b1;
                n_round = '0;
                n_state = S_SORT_DEV;
            end
            S_MAD: begin
                o_cmd.take_mad = 1'b1;
                n_state = S_JUDGE;
            end
            S_JUDGE: begin
                o_cmd.judge = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit       = 1'b1;
                    o_cmd.frame_done = r_last && (r_age == '0);
                    if (r_last && (r_age != '0)) begin
                        n_age   = r_age - 1'b1;
                        n_idx   = '0;
                        n_state = S_LOAD;
                    end else begin
                        o_cmd.pos_clear = r_last;
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `HOF_ASSERT_IMP(a_age_range, i_clk, i_rst_n, r_state == S_LOAD, r_age <= AW'(HALF_WINDOW))
    `HOF_ASSERT_IMP(a_len_nonzero, i_clk, i_rst_n, r_state == S_LOAD, len != '0)
    `HOF_ASSERT_NXT(a_flush_end, i_clk, i_rst_n, o_cmd.emit && o_cmd.frame_done, r_state == S_IDLE)

endmodule

### tb/hampel_outlier_filter_core_test.sv
// self-checking testbench for hampel_outlier_filter_core: framed samples in, cleaned samples out
// a built-in predictor tracks window, frame count and limit; depends on hof_pkg and the core rtl
`timescale 1ns / 1ps

module hampel_outlier_filter_core_test;
    import hof_pkg::*;

    localparam int HALF = 15;
    localparam int SPAN = 2 * HALF + 1;
    localparam int SETTLE = 150;        // > one result time, covers a beat in flight

    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_beat  in_data;
    logic      out_valid;
    logic      out_stall;
    t_out_beat out_data;
    logic      cfg_we;
    logic [LIMIT_BITS-1:0] cfg_data;

    // predictor state
    logic signed [SAMPLE_BITS-1:0] win_store [SPAN];
    int                    frame_cnt;
    int                    wr_slot;
    logic [LIMIT_BITS-1:0] limit_q;
    t_out_beat             cleaned_q [$];

    int  err_cnt;
    bit  idling_on;
    int  stall_left;

    hampel_outlier_filter_core #(.HALF_WINDOW(HALF)) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #15_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------
    function automatic void sort_vals(ref longint a[SPAN], input int n);
        longint k;
        int     j;
        for (int i = 1; i < n; i++) begin
            k = a[i];
            j = i;
            while (j > 0 && a[j-1] > k) begin
                a[j] = a[j-1];
                j--;
            end
            a[j] = k;
        end
    endfunction

    // age 0 is the newest sample
    function automatic longint stored_at(int age);
        return longint'(win_store[(wr_slot + SPAN - 1 - (age % SPAN)) % SPAN]);
    endfunction

    function automatic t_out_beat judge_centre(int age, int len);
        longint    vals [SPAN];
        longint    devs [SPAN];
        longint    centre, med, mad, gap;
        t_out_beat r;
        centre = stored_at(age);
        for (int i = 0; i < len; i++) vals[i] = stored_at(i);
        sort_vals(vals, len);
        med = vals[len / 2];
        for (int i = 0; i < len; i++)
            devs[i] = (vals[i] < med) ? med - vals[i] : vals[i] - med;
        sort_vals(devs, len);
        mad = devs[len / 2];
        gap = (centre < med) ? med - centre : centre - med;
        r.replaced   = (mad > 0) && (gap * 256 > longint'(limit_q) * mad);
        r.cleaned    = r.replaced ? med[SAMPLE_BITS-1:0] : centre[SAMPLE_BITS-1:0];
        r.frame_done = 1'b0;
        return r;
    endfunction

    function automatic int span_len(int age);
        return (frame_cnt < age + HALF + 1) ? frame_cnt : age + HALF + 1;
    endfunction

    function automatic void predict_beat(t_in_beat b);
        t_out_beat r;
        int        age;
        win_store[wr_slot] = b.sample;
        wr_slot = (wr_slot + 1) % SPAN;
        if (frame_cnt < SPAN) frame_cnt++;
        if (!b.frame_end) begin
            if (frame_cnt > HALF) cleaned_q.push_back(judge_centre(HALF, span_len(HALF)));
        end else begin
            // flush: oldest pending centre first, newest last
            age = (frame_cnt - 1 > HALF) ? HALF : frame_cnt - 1;
            while (age >= 0) begin
                r = judge_centre(age, span_len(age));
                if (age == 0) r.frame_done = 1'b1;
                cleaned_q.push_back(r);
                age--;
            end
            frame_cnt = 0;
        end
    endfunction

    // ---------------------------------------------------------------
    // result checking
    // ---------------------------------------------------------------
    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        err_cnt++;
    endtask

    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (cleaned_q.size() == 0) begin
                report_mismatch("result beat with nothing expected");
            end else begin
                want = cleaned_q.pop_front();
                if (out_data.cleaned !== want.cleaned)
                    report_mismatch($sformatf("cleaned %0d, want %0d",
                                    out_data.cleaned, want.cleaned));
                if (out_data.replaced !== want.replaced)
                    report_mismatch($sformatf("replaced %0b, want %0b",
                                    out_data.replaced, want.replaced));
                if (out_data.frame_done !== want.frame_done)
                    report_mismatch($sformatf("frame_done %0b, want %0b",
                                    out_data.frame_done, want.frame_done));
            end
        end
    end

    // receiver back-pressure in random bursts
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
        end else if (idling_on && $urandom_range(0, 7) == 0) begin
            out_stall  <= 1'b1;
            stall_left = $urandom_range(1, 10) - 1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------
    // called at a falling edge, returns at a falling edge with valid still high
    task automatic send_beat(logic signed [SAMPLE_BITS-1:0] smp, bit last);
        t_in_beat b;
        b.sample    = smp;
        b.frame_end = last;
        if (idling_on && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        do @(posedge i_clk); while (in_stall);
        predict_beat(b);
        @(negedge i_clk);
    endtask

    // pause the sender until every expected beat is back and the core is idle
    task automatic drain_results();
        in_valid <= 1'b0;
        while (cleaned_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic set_limit(logic [LIMIT_BITS-1:0] val);
        drain_results();
        cfg_we   <= 1'b1;
        cfg_data <= val;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        limit_q  = val;
    endtask

    // one frame around a random level, with occasional spikes and wild samples
    task automatic send_frame(int len);
        int level, spread, v;
        level  = $signed($urandom_range(0, 32'h1F_FFFF)) - 32'h10_0000;
        spread = 1 << $urandom_range(0, 14);
        for (int i = 0; i < len; i++) begin
            v = level + $signed($urandom_range(0, 2 * spread)) - spread;
            case ($urandom_range(0, 19))
                0, 1:    v = v + (($urandom_range(0, 1) != 0) ? 1 : -1) * spread * 40;
                2:       v = $urandom;
                3:       v = level;
                default: ;
            endcase
            send_beat(v[SAMPLE_BITS-1:0], i == len - 1);
        end
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------
    task automatic test_tiny_frames();
        send_beat(24'sh7F_FFFF, 1'b1);
        send_beat(24'sh80_0000, 1'b1);
        send_beat('0, 1'b1);
    endtask

    task automatic test_short_frames();
        // short frame with a spike at the top of the range
        send_beat(24'sd0, 1'b0);
        send_beat(24'sd10, 1'b0);
        send_beat(-24'sd10, 1'b0);
        send_beat(24'sd5, 1'b0);
        send_beat(24'sh7F_FFFF, 1'b0);
        send_beat(24'sd3, 1'b0);
        send_beat(-24'sd7, 1'b1);
        // flat frame, deviation zero so nothing is replaced
        repeat (3) send_beat(24'sd42, 1'b0);
        send_beat(24'sd42, 1'b1);
    endtask

    task automatic test_limit_extremes();
        set_limit('0);
        send_frame(20);
        set_limit('1);
        send_frame(20);
        drain_results();
    endtask

    task automatic test_random_frames(int n_items);
        int sent, len;
        sent = 0;
        while (sent < n_items) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(32, 60)
                                              : $urandom_range(1, 35);
            if ($urandom_range(0, 9) == 0) set_limit($urandom_range(0, 4095));
            send_frame(len);
            sent += len;
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        out_stall  = 1'b0;
        cfg_we     = 1'b0;
        cfg_data   = '0;
        err_cnt    = 0;
        idling_on  = 1'b1;
        stall_left = 0;
        frame_cnt  = 0;
        wr_slot    = 0;
        limit_q    = LIMIT_RESET;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_tiny_frames();
        test_short_frames();
        test_limit_extremes();
        test_random_frames(120);
        set_limit(LIMIT_RESET);
        test_random_frames(25);
        // closing stretch at full rate on both sides
        idling_on = 1'b0;
        test_random_frames(35);

        drain_results();
        if (err_cnt == 0 && cleaned_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/hof_pkg.sv
rtl/core/hof_datapath.sv
rtl/core/hof_ctrl.sv
rtl/core/hampel_outlier_filter_core.sv
tb/hampel_outlier_filter_core_test.sv
